// File: src/krc_pkg.sv
package krc_pkg;

   localparam int KEY_SIZE_DEFAULT    = 95;
   localparam int LENGTH_BITS_DEFAULT = 12;
   localparam int PAYLOAD_LENGTH_W    = 12;
   localparam int ROT_STEP            = 13;
   localparam int RSP_FIFO_DEPTH      = 8;

   localparam logic [7:0] XOR_VALUE = 8'd28;

   typedef enum logic [1:0] {
      STATUS_CHAR       = 2'd0,
      STATUS_EMPTY      = 2'd1,
      STATUS_NOT_IN_KEY = 2'd2,
      STATUS_TOO_SHORT  = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0]                  data_byte;
      logic                        first_byte;
      logic                        last_byte;
      logic [PAYLOAD_LENGTH_W-1:0] payload_length;
   } req_type;

   typedef struct packed {
      logic [7:0] plain_char;
      status_type status;
      logic       last;
   } rsp_type;

endpackage

// File: src/krc_mod_reduce.sv
module krc_mod_reduce
   import krc_pkg::*;
#(
   parameter int KEY_SIZE = KEY_SIZE_DEFAULT,
   parameter int IN_W     = 17
) (
   input  logic                        clock,
   input  logic                        load,
   input  logic [IN_W-1:0]             value,
   output logic [$clog2(KEY_SIZE)-1:0] remainder
);

   localparam int IW = $clog2(KEY_SIZE);
   // floor(2^IN_W / KEY_SIZE): quotient estimate is exact or one low
   localparam logic [IN_W-1:0] MULT = IN_W'((2 ** IN_W) / KEY_SIZE);

   logic [IN_W-1:0]   x_ff;
   logic [IN_W-1:0]   x2_ff;
   logic [IN_W-1:0]   q_ff;
   logic [IW-1:0]     rem_ff;
   logic [2*IN_W-1:0] prod;
   logic [IN_W-1:0]   qk;
   logic [IN_W-1:0]   rem_raw;
   logic [IN_W-1:0]   rem_in;

   assign prod    = (2*IN_W)'(x_ff) * (2*IN_W)'(MULT);
   assign qk      = IN_W'(q_ff * IN_W'(KEY_SIZE));
   assign rem_raw = x2_ff - qk;
   assign rem_in  = (rem_raw >= IN_W'(KEY_SIZE)) ? rem_raw - IN_W'(KEY_SIZE) : rem_raw;

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff <= value;
      end
      q_ff   <= prod[2*IN_W-1:IN_W];
      x2_ff  <= x_ff;
      rem_ff <= rem_in[IW-1:0];
   end

   assign remainder = rem_ff;

endmodule

// File: src/krc_rsp_fifo.sv
module krc_rsp_fifo
   import krc_pkg::*;
#(
   parameter int DEPTH = RSP_FIFO_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rsp_type                    push_data,
   output logic                       pop_valid,
   input  logic                       pop_ready,
   output rsp_type                    pop_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   rsp_type        store [DEPTH];
   logic [PW-1:0]  wr_ptr_ff;
   logic [PW-1:0]  rd_ptr_ff;
   logic [CW-1:0]  count_ff;
   logic           pop;

   assign pop = pop_valid & pop_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign pop_valid = (count_ff != '0);
   assign pop_data  = store[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// File: src/keyed_rotation_cipher_decode_unit.sv
// Keyed rotation cipher decoder. One request per clock is accepted while the
// credit check passes: results in flight plus those held in the 8-entry
// response FIFO must stay below its depth, so with the response side ready
// the unit runs at one byte per cycle. A result goes through the three-stage
// pipeline (reverse map read, key table read, output format) and is written
// into the response FIFO as it leaves the third stage, and rsp_valid shows it
// from that write on. The header's rotation is reduced modulo KEY_SIZE by a
// registered reciprocal multiply that finishes before the first payload byte
// needs it. The per-character presence flags sit in flip-flops and clear in
// the cycle a first byte is taken, so there is no clearing pass after reset.
module keyed_rotation_cipher_decode_unit
   import krc_pkg::*;
#(
   parameter int KEY_SIZE    = KEY_SIZE_DEFAULT,
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IW   = $clog2(KEY_SIZE);
   localparam int TW   = $clog2(3 * KEY_SIZE);
   localparam int CAP  = KEY_SIZE + 1 + 2 ** LENGTH_BITS;
   localparam int IDXW = $clog2(CAP + 1);
   localparam int RW   = LENGTH_BITS + 6;
   localparam int K13  = KEY_SIZE * ((ROT_STEP + KEY_SIZE - 1) / KEY_SIZE);
   localparam int XW   = $clog2(2 ** LENGTH_BITS + 256 + K13);
   localparam int S13  = ROT_STEP % KEY_SIZE;
   localparam int CW   = $clog2(RSP_FIFO_DEPTH + 1);

   // control state
   logic [IDXW-1:0]        idx_ff;
   logic [LENGTH_BITS-1:0] len_ff;
   logic                   aborted_ff;
   logic [RW-1:0]          raw_ff;
   logic [IW-1:0]          delta_ff;
   logic [255:0]           present_ff;

   logic [IDXW-1:0]        idx_in;
   logic [LENGTH_BITS-1:0] len_in;
   logic                   aborted_in;
   logic [RW-1:0]          raw_in;
   logic [IW-1:0]          delta_in;
   logic [255:0]           present_in;

   logic                   accept;
   logic                   first;
   logic                   last_req;
   logic [7:0]             c;
   logic [IDXW-1:0]        eff_idx;
   logic                   eff_abort;
   logic [RW-1:0]          eff_raw;
   logic                   act;
   logic                   in_key;
   logic                   in_hdr;
   logic                   in_body;
   logic                   body_fin;
   logic                   hit;
   logic                   rot_zero;
   logic                   key_we;
   logic                   map_we;
   logic                   hdr_load;
   logic                   body_step;
   logic [IW:0]            delta_sum;
   logic [XW-1:0]          hdr_x;
   logic [IW-1:0]          base;

   logic                   res_v;
   status_type             res_status;
   logic                   res_last;
   logic                   res_lookup;
   logic                   abort_set;

   // pipeline
   logic                   s1_v_ff, s2_v_ff, s3_v_ff;
   logic                   s1_kwe_ff, s2_kwe_ff;
   status_type             s1_status_ff, s2_status_ff, s3_status_ff;
   logic                   s1_last_ff, s2_last_ff, s3_last_ff;
   logic                   s1_lookup_ff, s2_lookup_ff, s3_lookup_ff;
   logic [7:0]             s1_c_ff, s2_c_ff, s3_c_ff;
   logic [IW-1:0]          s1_delta_ff, s2_delta_ff;
   logic [IW-1:0]          s1_kidx_ff, s2_kidx_ff;
   logic [IW-1:0]          map_rd_ff, s2_map_ff;
   logic [7:0]             key_rd_ff;
   logic [TW-1:0]          pos_sum;
   logic [IW-1:0]          pos;

   logic [IW-1:0]          reverse_map [256];
   logic [7:0]             key_table [KEY_SIZE];

   rsp_type                rsp_in;
   logic [CW-1:0]          fifo_count;
   logic [CW-1:0]          in_flight;

   assign accept   = req_valid & req_ready;
   assign first    = req_data.first_byte;
   assign last_req = req_data.last_byte;
   assign c        = req_data.data_byte ^ XOR_VALUE;

   // a first byte restarts the message before the byte itself is handled
   assign eff_idx   = first ? '0 : idx_ff;
   assign eff_abort = ~first & aborted_ff;
   assign eff_raw   = first ? '0 : raw_ff;
   assign len_in    = first ? LENGTH_BITS'(req_data.payload_length) : len_ff;
   assign hit       = ~first & present_ff[c];

   assign act      = accept & ~eff_abort;
   assign in_key   = eff_idx < IDXW'(KEY_SIZE);
   assign in_hdr   = eff_idx == IDXW'(KEY_SIZE);
   assign in_body  = ~in_key & ~in_hdr & (eff_idx < IDXW'(KEY_SIZE + 1) + IDXW'(len_in));
   assign body_fin = last_req | (eff_idx == IDXW'(KEY_SIZE) + IDXW'(len_in));
   assign rot_zero = eff_raw == '0;

   assign key_we    = act & in_key;
   assign map_we    = key_we & ~hit;
   assign hdr_load  = act & in_hdr & (len_in != '0) & ~last_req;
   assign body_step = act & in_body & (rot_zero | hit);

   // nonnegative stand-in for length + header - 13, same residue mod KEY_SIZE
   assign hdr_x = XW'(len_in) + XW'(c) + XW'(K13 - ROT_STEP);

   always_comb begin
      res_v      = 1'b0;
      res_status = STATUS_CHAR;
      res_last   = 1'b0;
      res_lookup = 1'b0;
      abort_set  = 1'b0;
      if (act) begin
         if (in_key) begin
            if (last_req) begin
               res_v      = 1'b1;
               res_status = STATUS_TOO_SHORT;
               res_last   = 1'b1;
               abort_set  = 1'b1;
            end
         end else if (in_hdr) begin
            if (len_in == '0 || last_req) begin
               res_v      = 1'b1;
               res_status = STATUS_EMPTY;
               res_last   = 1'b1;
               abort_set  = 1'b1;
            end
         end else if (in_body) begin
            res_v = 1'b1;
            if (rot_zero || hit) begin
               res_status = STATUS_CHAR;
               res_last   = body_fin;
               res_lookup = ~rot_zero;
               abort_set  = body_fin;
            end else begin
               res_status = STATUS_NOT_IN_KEY;
               res_last   = 1'b1;
               abort_set  = 1'b1;
            end
         end else begin
            abort_set = last_req;
         end
      end
   end

   assign delta_sum = (IW+1)'(delta_ff) + (IW+1)'(S13);

   always_comb begin
      idx_in = eff_idx;
      if (act && eff_idx < IDXW'(CAP)) begin
         idx_in = eff_idx + 1'b1;
      end
      aborted_in = eff_abort | abort_set;
      raw_in     = eff_raw;
      delta_in   = delta_ff;
      if (hdr_load) begin
         raw_in   = RW'(len_in) + RW'(c) - RW'(ROT_STEP);
         delta_in = '0;
      end else if (body_step) begin
         raw_in   = eff_raw - RW'(ROT_STEP);
         delta_in = (delta_sum >= (IW+1)'(KEY_SIZE)) ?
                    IW'(delta_sum - (IW+1)'(KEY_SIZE)) : IW'(delta_sum);
      end
      present_in = first ? '0 : present_ff;
      if (map_we) begin
         present_in = present_in | (256'(1) << c);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         len_ff     <= '0;
         aborted_ff <= 1'b0;
         raw_ff     <= '0;
         delta_ff   <= '0;
         present_ff <= '0;
      end else if (accept) begin
         idx_ff     <= idx_in;
         len_ff     <= len_in;
         aborted_ff <= aborted_in;
         raw_ff     <= raw_in;
         delta_ff   <= delta_in;
         present_ff <= present_in;
      end
   end

   krc_mod_reduce #(
      .KEY_SIZE (KEY_SIZE),
      .IN_W     (XW)
   ) u_mod_reduce (
      .clock     (clock),
      .load      (hdr_load),
      .value     (hdr_x),
      .remainder (base)
   );

   // reverse map: first key position of each character
   always_ff @(posedge clock) begin
      if (map_we) begin
         reverse_map[c] <= eff_idx[IW-1:0];
      end
      map_rd_ff <= reverse_map[c];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff   <= 1'b0;
         s1_kwe_ff <= 1'b0;
         s2_v_ff   <= 1'b0;
         s2_kwe_ff <= 1'b0;
         s3_v_ff   <= 1'b0;
      end else begin
         s1_v_ff   <= res_v;
         s1_kwe_ff <= key_we;
         s2_v_ff   <= s1_v_ff;
         s2_kwe_ff <= s1_kwe_ff;
         s3_v_ff   <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_status_ff <= res_status;
      s1_last_ff   <= res_last;
      s1_lookup_ff <= res_lookup;
      s1_c_ff      <= c;
      s1_delta_ff  <= delta_ff;
      s1_kidx_ff   <= eff_idx[IW-1:0];

      s2_status_ff <= s1_status_ff;
      s2_last_ff   <= s1_last_ff;
      s2_lookup_ff <= s1_lookup_ff;
      s2_c_ff      <= s1_c_ff;
      s2_delta_ff  <= s1_delta_ff;
      s2_kidx_ff   <= s1_kidx_ff;
      s2_map_ff    <= map_rd_ff;

      s3_status_ff <= s2_status_ff;
      s3_last_ff   <= s2_last_ff;
      s3_lookup_ff <= s2_lookup_ff;
      s3_c_ff      <= s2_c_ff;
   end

   // (map + base - delta) mod KEY_SIZE, sum stays in (0, 3*KEY_SIZE)
   assign pos_sum = TW'(s2_map_ff) + TW'(base) + TW'(KEY_SIZE) - TW'(s2_delta_ff);

   always_comb begin
      if (pos_sum >= TW'(2 * KEY_SIZE)) begin
         pos = IW'(pos_sum - TW'(2 * KEY_SIZE));
      end else if (pos_sum >= TW'(KEY_SIZE)) begin
         pos = IW'(pos_sum - TW'(KEY_SIZE));
      end else begin
         pos = IW'(pos_sum);
      end
   end

   // key writes ride the pipeline so reads and writes keep request order
   always_ff @(posedge clock) begin
      if (s2_kwe_ff) begin
         key_table[s2_kidx_ff] <= s2_c_ff;
      end
      key_rd_ff <= key_table[pos];
   end

   always_comb begin
      rsp_in.status = s3_status_ff;
      rsp_in.last   = s3_last_ff;
      if (s3_status_ff != STATUS_CHAR) begin
         rsp_in.plain_char = '0;
      end else if (s3_lookup_ff) begin
         rsp_in.plain_char = key_rd_ff;
      end else begin
         rsp_in.plain_char = s3_c_ff;
      end
   end

   krc_rsp_fifo #(
      .DEPTH (RSP_FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s3_v_ff),
      .push_data (rsp_in),
      .pop_valid (rsp_valid),
      .pop_ready (rsp_ready),
      .pop_data  (rsp_data),
      .count     (fifo_count)
   );

   // every result in the pipeline has a FIFO slot reserved
   assign in_flight = fifo_count + CW'(s1_v_ff) + CW'(s2_v_ff) + CW'(s3_v_ff);
   assign req_ready = in_flight < CW'(RSP_FIFO_DEPTH);

endmodule

// File: sim/keyed_rotation_cipher_decode_unit_tb.sv
import krc_pkg::*;

class plaintext_tracker;
   logic [7:0]  key_chars [KEY_SIZE_DEFAULT];
   logic [6:0]  first_pos [256];
   bit          seen [256];
   int unsigned byte_count;
   int          rot_raw;
   int unsigned rot_mod;
   int unsigned msg_len;
   bit          finished;
   rsp_type     expected_out [$];
   int          errors;

   function new();
      seen = '{default: 1'b0};
      byte_count = 0;
      rot_raw = 0;
      rot_mod = 0;
      msg_len = 0;
      finished = 1'b0;
      errors = 0;
   endfunction

   function void set_rotation(int v);
      int m;
      m = v % KEY_SIZE_DEFAULT;
      if (m < 0) m += KEY_SIZE_DEFAULT;
      rot_raw = v;
      rot_mod = m;
   endfunction

   function void push(logic [7:0] ch, status_type st, logic lst);
      rsp_type e;
      e.plain_char = ch;
      e.status = st;
      e.last = lst;
      expected_out.push_back(e);
   endfunction

   // advance the decoder state by one accepted request
   function void take_byte(req_type r);
      logic [7:0]  c;
      logic [7:0]  ch;
      int unsigned idx;
      int unsigned pi;
      int unsigned cap;
      bit          fin;
      c = r.data_byte ^ XOR_VALUE;
      cap = KEY_SIZE_DEFAULT + 1 + (1 << LENGTH_BITS_DEFAULT);
      if (r.first_byte) begin
         seen = '{default: 1'b0};
         byte_count = 0;
         msg_len = r.payload_length & ((1 << LENGTH_BITS_DEFAULT) - 1);
         set_rotation(0);
         finished = 1'b0;
      end
      if (finished) return;
      idx = byte_count;
      if (byte_count < cap) byte_count++;
      if (idx < KEY_SIZE_DEFAULT) begin
         key_chars[idx] = c;
         if (!seen[c]) begin
            seen[c] = 1'b1;
            first_pos[c] = idx[6:0];
         end
         if (r.last_byte) begin
            finished = 1'b1;
            push(8'd0, STATUS_TOO_SHORT, 1'b1);
         end
         return;
      end
      if (idx == KEY_SIZE_DEFAULT) begin
         if (msg_len == 0 || r.last_byte) begin
            finished = 1'b1;
            push(8'd0, STATUS_EMPTY, 1'b1);
         end else begin
            set_rotation(int'(msg_len) + int'(c) - ROT_STEP);
         end
         return;
      end
      pi = idx - KEY_SIZE_DEFAULT - 1;
      if (pi >= msg_len) begin
         if (r.last_byte) finished = 1'b1;
         return;
      end
      fin = r.last_byte || (pi + 1 == msg_len);
      if (rot_raw == 0) begin
         ch = c;
      end else if (!seen[c]) begin
         finished = 1'b1;
         push(8'd0, STATUS_NOT_IN_KEY, 1'b1);
         return;
      end else begin
         ch = key_chars[(first_pos[c] + rot_mod) % KEY_SIZE_DEFAULT];
      end
      set_rotation(rot_raw - ROT_STEP);
      if (fin) finished = 1'b1;
      push(ch, STATUS_CHAR, fin);
   endfunction

   function void complain(string field, int want, int got);
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
   endfunction

   function void match_output(rsp_type got);
      rsp_type want;
      if (expected_out.size() == 0) begin
         errors++;
         $display("%0t: result expected none actual char %0d status %0d last %0d",
                  $time, got.plain_char, got.status, got.last);
         return;
      end
      want = expected_out.pop_front();
      if (got.plain_char !== want.plain_char)
         complain("plain_char", want.plain_char, got.plain_char);
      if (got.status !== want.status)
         complain("status", int'(want.status), int'(got.status));
      if (got.last !== want.last)
         complain("last", want.last, got.last);
   endfunction
endclass

module keyed_rotation_cipher_decode_unit_tb;
   localparam int KEY          = KEY_SIZE_DEFAULT;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int TOTAL_BYTES  = 1600;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   plaintext_tracker tracker = new();
   int cycle_count = 0;
   int bytes_sent = 0;
   int send_left = 0;
   int take_left = 0;
   bit send_calm = 1'b0;
   bit take_calm = 1'b0;

   keyed_rotation_cipher_decode_unit #(
      .KEY_SIZE    (KEY_SIZE_DEFAULT),
      .LENGTH_BITS (LENGTH_BITS_DEFAULT)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) tracker.take_byte(req_data);
         if (rsp_valid && rsp_ready) tracker.match_output(rsp_data);
      end
   end

   // busy and calm stretches are mixed at random so back-to-back traffic also shows up
   function automatic int next_wait(inout int left, inout bit calm);
      if (left == 0) begin
         left = $urandom_range(1, 40);
         calm = ($urandom_range(0, 3) == 0);
      end
      left--;
      return calm ? 0 : $urandom_range(0, 7);
   endfunction

   task automatic send_byte(input logic [7:0] ch, input bit first, input bit last,
                            input logic [11:0] len);
      int      gap;
      req_type r;
      gap = next_wait(send_left, send_calm);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      r.data_byte = ch ^ XOR_VALUE;
      r.first_byte = first;
      r.last_byte = last;
      r.payload_length = len;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   // key kinds: 0 printable permutation, 1 random with repeats,
   // 2 distinct over all byte values, 3 printable with a zero planted
   task automatic send_message(input bit with_first, input int len_field,
                               input int key_kind, input int hdr, input int count,
                               input int stop_at, input int foreign_pct);
      logic [7:0] key [KEY];
      bit         in_key [256];
      logic [7:0] pool [256];
      logic [7:0] ch;
      logic [7:0] tmp;
      int         j;
      int         span;
      in_key = '{default: 1'b0};
      span = (key_kind == 0 || key_kind == 3) ? KEY : 256;
      for (int i = 0; i < 256; i++) pool[i] = (span == KEY) ? 8'(32 + i) : 8'(i);
      for (int i = span - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = pool[i];
         pool[i] = pool[j];
         pool[j] = tmp;
      end
      for (int i = 0; i < KEY; i++) key[i] = (key_kind == 1) ? 8'($urandom) : pool[i];
      if (key_kind == 3) key[$urandom_range(0, KEY - 1)] = 8'd0;
      for (int i = 0; i < KEY; i++) in_key[key[i]] = 1'b1;
      for (int i = 0; i < count; i++) begin
         if (i < KEY) begin
            ch = key[i];
         end else if (i == KEY) begin
            ch = hdr[7:0];
         end else if ($urandom_range(1, 100) <= foreign_pct) begin
            do ch = 8'($urandom); while (in_key[ch]);
         end else begin
            ch = key[$urandom_range(0, KEY - 1)];
         end
         send_byte(ch, with_first && i == 0, i == stop_at,
                   (i == 0) ? len_field[11:0] : 12'($urandom));
         bytes_sent++;
      end
   endtask

   task automatic send_noise(input int n);
      repeat (n)
         send_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                   12'($urandom));
   endtask

   initial begin
      int stall;
      wait (reset === 1'b0);
      forever begin
         stall = next_wait(take_left, take_calm);
         repeat (stall) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int target;
      int pick;
      int kind;
      int len;
      int hdr;
      int count;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no first byte after reset: behaves as a message with zero length
      send_message(0, 0, 0, 65, KEY + 3, -1, 0);
      // too short, on the first key byte and on the last one
      send_message(1, 7, 2, 0, 1, 0, 0);
      send_message(1, 7, 1, 0, KEY, KEY - 1, 0);
      // empty payload: last on the header, then a zero length
      send_message(1, 9, 0, 255, KEY + 1, KEY, 0);
      send_message(1, 0, 2, 3, KEY + 2, -1, 0);
      // rotation hits zero on the third payload byte (5 + 34 - 39)
      send_message(1, 5, 3, 34, KEY + 6, KEY + 5, 0);
      // zero rotation passes a character that is not in the key; a nonzero one flags it
      send_message(1, 1, 0, 12, KEY + 2, KEY + 1, 100);
      send_message(1, 4, 0, 200, KEY + 5, KEY + 4, 100);
      // payload cut short by last_byte
      send_message(1, 4095, 2, 255, KEY + 7, KEY + 6, 0);
      // bytes past the payload with last on an ignored byte, then last on the final payload byte
      send_message(1, 3, 1, 0, KEY + 8, KEY + 7, 0);
      send_message(1, 2, 2, 0, KEY + 3, KEY + 2, 0);

      target = TOTAL_BYTES;
      while (bytes_sent < target) begin
         pick = $urandom_range(0, 99);
         kind = $urandom_range(0, 3);
         len = $urandom_range(1, 24);
         if ($urandom_range(0, 15) == 0) len = $urandom_range(25, 120);
         hdr = $urandom_range(0, 255);
         if ($urandom_range(0, 3) == 0) begin
            hdr = 13 * $urandom_range(1, len) - len;
            if (hdr < 0 || hdr > 255) hdr = $urandom_range(0, 255);
         end
         if (pick < 60) begin
            send_message(1, len, kind, hdr, KEY + 1 + len, KEY + len,
                         ($urandom_range(0, 3) == 0) ? 4 : 0);
         end else if (pick < 70) begin
            send_message(1, $urandom_range(0, 4095), kind, hdr, KEY + 1 + len, KEY + len, 0);
         end else if (pick < 77) begin
            count = KEY + 1 + len + $urandom_range(1, 4);
            send_message(1, len, kind, hdr, count,
                         $urandom_range(0, 1) ? count - 1 : -1, 0);
         end else if (pick < 83) begin
            count = $urandom_range(1, KEY);
            send_message(1, len, kind, hdr, count, count - 1, 0);
         end else if (pick < 89) begin
            if ($urandom_range(0, 1))
               send_message(1, 0, kind, hdr, KEY + 1, -1, 0);
            else
               send_message(1, len, kind, hdr, KEY + 1, KEY, 0);
         end else begin
            send_noise($urandom_range(1, 6));
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (tracker.expected_out.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (tracker.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

// File: keyed_rotation_cipher_decode_unit.f
src/krc_pkg.sv
src/krc_mod_reduce.sv
src/krc_rsp_fifo.sv
src/keyed_rotation_cipher_decode_unit.sv
sim/keyed_rotation_cipher_decode_unit_tb.sv
